[src/mmt_pkg.sv]
// Package for the A times B-transpose block: field widths, sizes and
// register indexes shared by the interfaces, the datapath and the checker.
// Depends on nothing.
package mmt_pkg;

   // Sizes of the stationary B store and the accumulator bank
   localparam int MAX_B_ROWS  = 64;
   localparam int MAX_ROW_LEN = 256;
   localparam int STORE_DEPTH = MAX_B_ROWS * MAX_ROW_LEN;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int ROW_SEL_W   = (MAX_B_ROWS > 1) ? $clog2(MAX_B_ROWS) : 1;
   localparam int COL_W       = (MAX_ROW_LEN > 1) ? $clog2(MAX_ROW_LEN) : 1;

   // Register and field widths
   localparam int NB_W    = 7;
   localparam int RL_W    = 9;
   localparam int NA_W    = 16;
   localparam int VALUE_W = 16;
   localparam int PROD_W  = 2 * VALUE_W;
   localparam int DOT_W   = 40;
   localparam int BROW_W  = 6;
   localparam int AROW_W  = 16;
   localparam int TOT_W   = NB_W + RL_W;

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NUM_B_ROWS = 2'd0,
      CSR_ROW_LENGTH = 2'd1,
      CSR_NUM_A_ROWS = 2'd2
   } csr_index_type;

   // Input action codes
   localparam logic ACT_LOAD_B = 1'b0;
   localparam logic ACT_FEED_A = 1'b1;

   // Register reset values
   localparam logic [NB_W-1:0] NUM_B_ROWS_RESET = NB_W'(64);
   localparam logic [RL_W-1:0] ROW_LENGTH_RESET = RL_W'(256);
   localparam logic [NA_W-1:0] NUM_A_ROWS_RESET = NA_W'(1);

endpackage

[src/mmt_if.sv]
// Channel interfaces of the A times B-transpose block: input beats,
// result beats and configuration writes. Depends on mmt_pkg.
interface mmt_req_if import mmt_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic                      action;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, output action, output value, input ready);
   modport sink   (input valid, input action, input value, output ready);
endinterface

interface mmt_rsp_if import mmt_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [DOT_W-1:0] dot_value;
   logic [BROW_W-1:0]       b_row_index;
   logic [AROW_W-1:0]       a_row_index;
   logic                    last;

   modport source (output valid, output dot_value, output b_row_index,
                   output a_row_index, output last, input ready);
   modport sink   (input valid, input dot_value, input b_row_index,
                   input a_row_index, input last, output ready);
endinterface

interface mmt_csr_if import mmt_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[src/mmt_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module mmt_ram #(
   parameter int WIDTH      = 16,
   parameter int DEPTH      = 256,
   parameter int ADDR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_WIDTH-1:0] wr_addr,
   input  logic [WIDTH-1:0]      wr_data,
   input  logic                  rd_en,
   input  logic [ADDR_WIDTH-1:0] rd_addr,
   output logic [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/matrix_multiply_transposed.sv]
// Top level of C = A * B-transpose with B stationary, one shared MAC.
// B beat: written straight into the store, B beats can follow back to back.
// A beat: the next beat waits until B and the accumulator have been read,
// multiplied and added for each B row in turn, longer while a result beat stalls.
// Reset (synchronous) restores register defaults, counters and accumulator
// valid bits; the B store keeps its contents and needs no clearing pass.
module matrix_multiply_transposed import mmt_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   mmt_req_if.sink   req_if,
   mmt_rsp_if.source rsp_if,
   mmt_csr_if.sink   csr_if
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_READ = 4'b0010,
      ST_MUL  = 4'b0100,
      ST_ACC  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers
   logic [NB_W-1:0] num_b_rows_ff;
   logic [RL_W-1:0] row_length_ff;
   logic [NA_W-1:0] num_a_rows_ff;

   // Counters and sequencer state
   logic [ADDR_W-1:0]     wpos_ff, wpos_in;
   logic [COL_W-1:0]      col_pos_ff, col_pos_in;
   logic [AROW_W-1:0]     row_cnt_ff, row_cnt_in;
   logic [MAX_B_ROWS-1:0] acc_valid_ff, acc_valid_in;
   logic [ROW_SEL_W-1:0]  j_ff, j_in;
   logic                  row_end_ff, row_end_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // Datapath registers
   logic [TOT_W-1:0]          base_ff, base_in;
   logic signed [VALUE_W-1:0] a_val_ff, a_val_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [DOT_W-1:0]   acc_cur_ff, acc_cur_in;
   logic signed [DOT_W-1:0]   dot_ff;
   logic [BROW_W-1:0]         brow_ff;
   logic [AROW_W-1:0]         arow_ff;
   logic                      last_ff;

   // Clamped register values
   logic [NB_W-1:0]  nb;
   logic [RL_W-1:0]  rl;
   logic [NA_W-1:0]  na;
   logic [TOT_W-1:0] total;

   logic                  req_fire;
   logic                  rsp_free;
   logic                  rsp_load;
   logic                  j_last;
   logic [ADDR_W-1:0]     wpos_cur;
   logic [ADDR_W:0]       wpos_nxt;
   logic [COL_W-1:0]      col_sel;
   logic [NA_W:0]         row_cnt_nxt;
   logic signed [DOT_W-1:0] sum;

   // RAM ports
   logic                  b_wr_en;
   logic                  b_rd_en;
   logic [VALUE_W-1:0]    b_rd_data;
   logic                  acc_wr_en;
   logic                  acc_rd_en;
   logic [DOT_W-1:0]      acc_rd_data;

   // Saturate registers into their legal ranges
   always_comb begin
      if (num_b_rows_ff == '0) begin
         nb = NB_W'(1);
      end else if (32'(num_b_rows_ff) > MAX_B_ROWS) begin
         nb = NB_W'(MAX_B_ROWS);
      end else begin
         nb = num_b_rows_ff;
      end
      if (row_length_ff == '0) begin
         rl = RL_W'(1);
      end else if (32'(row_length_ff) > MAX_ROW_LEN) begin
         rl = RL_W'(MAX_ROW_LEN);
      end else begin
         rl = row_length_ff;
      end
      na = (num_a_rows_ff == '0) ? NA_W'(1) : num_a_rows_ff;
   end

   assign total = TOT_W'(nb) * TOT_W'(rl);

   assign req_fire = req_if.valid && req_if.ready;
   assign req_if.ready = (state_ff == ST_IDLE);
   assign csr_if.ready = 1'b1;
   assign rsp_free = !rsp_valid_ff || rsp_if.ready;
   assign j_last = ((NB_W + 1)'(j_ff) + (NB_W + 1)'(1)) == (NB_W + 1)'(nb);

   // B write position, wrapped at the loaded matrix size
   assign wpos_cur = (TOT_W'(wpos_ff) >= total) ? '0 : wpos_ff;
   assign wpos_nxt = (ADDR_W + 1)'(wpos_cur) + (ADDR_W + 1)'(1);

   // Column of B used by this A beat
   assign col_sel = ((RL_W + 1)'(col_pos_ff) < (RL_W + 1)'(rl)) ? col_pos_ff
                                                                : COL_W'(rl - RL_W'(1));

   assign row_cnt_nxt = (NA_W + 1)'(row_cnt_ff) + (NA_W + 1)'(1);

   // Shared MAC: multiply, then add into the selected accumulator
   assign prod_in    = a_val_ff * $signed(b_rd_data);
   assign acc_cur_in = acc_valid_ff[j_ff] ? $signed(acc_rd_data) : '0;
   assign sum        = acc_cur_ff + DOT_W'(prod_ff);

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      wpos_in      = wpos_ff;
      col_pos_in   = col_pos_ff;
      row_cnt_in   = row_cnt_ff;
      acc_valid_in = acc_valid_ff;
      j_in         = j_ff;
      row_end_in   = row_end_ff;
      base_in      = base_ff;
      a_val_in     = a_val_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      b_wr_en      = 1'b0;
      b_rd_en      = 1'b0;
      acc_wr_en    = 1'b0;
      acc_rd_en    = 1'b0;
      rsp_load     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_if.action == ACT_LOAD_B) begin
                  b_wr_en = 1'b1;
                  wpos_in = (TOT_W'(wpos_nxt) >= total) ? '0 : ADDR_W'(wpos_nxt);
               end else begin
                  a_val_in   = req_if.value;
                  row_end_in = ((RL_W + 1)'(col_pos_ff) + (RL_W + 1)'(1))
                               >= (RL_W + 1)'(rl);
                  base_in    = TOT_W'(col_sel);
                  j_in       = '0;
                  state_in   = ST_READ;
               end
            end
         end
         ST_READ: begin
            b_rd_en   = 1'b1;
            acc_rd_en = 1'b1;
            state_in  = ST_MUL;
         end
         ST_MUL: begin
            state_in = ST_ACC;
         end
         ST_ACC: begin
            // Hold while a finished row waits for the result register
            if (!row_end_ff || rsp_free) begin
               if (row_end_ff) begin
                  rsp_load     = 1'b1;
                  rsp_valid_in = 1'b1;
               end else begin
                  acc_wr_en          = 1'b1;
                  acc_valid_in[j_ff] = 1'b1;
               end
               if (j_last) begin
                  state_in = ST_IDLE;
                  if (row_end_ff) begin
                     acc_valid_in = '0;
                     col_pos_in   = '0;
                     row_cnt_in   = (row_cnt_nxt >= (NA_W + 1)'(na)) ? '0
                                                                     : AROW_W'(row_cnt_nxt);
                  end else begin
                     col_pos_in = col_pos_ff + COL_W'(1);
                  end
               end else begin
                  j_in     = j_ff + ROW_SEL_W'(1);
                  base_in  = base_ff + TOT_W'(rl);
                  state_in = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers and configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         num_b_rows_ff <= NUM_B_ROWS_RESET;
         row_length_ff <= ROW_LENGTH_RESET;
         num_a_rows_ff <= NUM_A_ROWS_RESET;
         wpos_ff       <= '0;
         col_pos_ff    <= '0;
         row_cnt_ff    <= '0;
         acc_valid_ff  <= '0;
         j_ff          <= '0;
         row_end_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wpos_ff      <= wpos_in;
         col_pos_ff   <= col_pos_in;
         row_cnt_ff   <= row_cnt_in;
         acc_valid_ff <= acc_valid_in;
         j_ff         <= j_in;
         row_end_ff   <= row_end_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_if.valid && csr_if.ready) begin
            unique case (csr_if.index)
               CSR_NUM_B_ROWS: num_b_rows_ff <= NB_W'(csr_if.data);
               CSR_ROW_LENGTH: row_length_ff <= RL_W'(csr_if.data);
               CSR_NUM_A_ROWS: num_a_rows_ff <= NA_W'(csr_if.data);
               default: ;
            endcase
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      base_ff  <= base_in;
      a_val_ff <= a_val_in;
      if (state_ff == ST_MUL) begin
         prod_ff    <= prod_in;
         acc_cur_ff <= acc_cur_in;
      end
      if (rsp_load) begin
         dot_ff  <= sum;
         brow_ff <= BROW_W'(j_ff);
         arow_ff <= row_cnt_ff;
         last_ff <= j_last;
      end
   end

   // Stationary B store
   mmt_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (STORE_DEPTH)
   ) u_b_store (
      .clock   (clock),
      .wr_en   (b_wr_en),
      .wr_addr (wpos_cur),
      .wr_data (req_if.value),
      .rd_en   (b_rd_en),
      .rd_addr (base_ff[ADDR_W-1:0]),
      .rd_data (b_rd_data)
   );

   // One accumulator per B row
   mmt_ram #(
      .WIDTH (DOT_W),
      .DEPTH (MAX_B_ROWS)
   ) u_acc_bank (
      .clock   (clock),
      .wr_en   (acc_wr_en),
      .wr_addr (j_ff),
      .wr_data (sum),
      .rd_en   (acc_rd_en),
      .rd_addr (j_ff),
      .rd_data (acc_rd_data)
   );

   // Result beat
   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.dot_value   = dot_ff;
   assign rsp_if.b_row_index = brow_ff;
   assign rsp_if.a_row_index = arow_ff;
   assign rsp_if.last        = last_ff;

endmodule

[src/mmt_checker.sv]
// Port-level checks for matrix_multiply_transposed and the bind that
// attaches them. Depends on mmt_pkg and the top level.
module mmt_checker import mmt_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              req_action,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [DOT_W-1:0]  rsp_dot_value,
   input logic [BROW_W-1:0] rsp_b_row_index,
   input logic              rsp_last
);

   // A stalled result beat stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped while stalled");

   // A stalled result beat keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable(rsp_dot_value) && $stable(rsp_b_row_index) && $stable(rsp_last))
      else $error("result payload changed while stalled");

   // An A beat occupies the shared MAC: no beat is taken in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_action == ACT_FEED_A) |=> !req_ready)
      else $error("input taken while MAC busy");

   // A B beat is a direct store write: ready again at once
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_action == ACT_LOAD_B) |=> req_ready)
      else $error("input stalled after B load");

   // Reset leaves no result beat pending
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result beat offered after reset");

endmodule

bind matrix_multiply_transposed mmt_checker u_mmt_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_if.valid),
   .req_ready       (req_if.ready),
   .req_action      (req_if.action),
   .rsp_valid       (rsp_if.valid),
   .rsp_ready       (rsp_if.ready),
   .rsp_dot_value   (rsp_if.dot_value),
   .rsp_b_row_index (rsp_if.b_row_index),
   .rsp_last        (rsp_if.last)
);

[tb/matrix_multiply_transposed_checker.sv]
// Scoreboard for the A times B-transpose block: keeps its own B store, row sums
// and counters, and matches every result beat against the oldest prediction.
// Depends on mmt_pkg and the channel interfaces in mmt_if.
module matrix_multiply_transposed_checker import mmt_pkg::*; (
   input  logic clock,
   input  logic reset,
   mmt_req_if   req_if,
   mmt_rsp_if   rsp_if,
   mmt_csr_if   csr_if,
   output int   fail_count,
   output int   pending,
   output int   checked
);

   typedef struct packed {
      logic signed [DOT_W-1:0] dot_value;
      logic [BROW_W-1:0]       b_row_index;
      logic [AROW_W-1:0]       a_row_index;
      logic                    last;
   } dot_beat_type;

   dot_beat_type              dot_queue [$];
   logic signed [VALUE_W-1:0] b_matrix [STORE_DEPTH];
   logic [DOT_W-1:0]          row_sums [MAX_B_ROWS];
   logic [NB_W-1:0]           nb_reg;
   logic [RL_W-1:0]           rl_reg;
   logic [NA_W-1:0]           na_reg;
   int unsigned               load_pos;
   int unsigned               col_pos;
   int unsigned               a_row_count;
   int                        fails = 0;
   int                        matched = 0;

   // Zero acts as one, oversized values saturate at the store size
   function automatic int unsigned clamp_size(input int unsigned raw, input int unsigned hi);
      if (raw == 0) return 1;
      return (raw > hi) ? hi : raw;
   endfunction

   // Write the next B element; the position wraps at the current matrix size
   task automatic store_b_element(input logic signed [VALUE_W-1:0] v);
      int unsigned total;
      total = clamp_size(nb_reg, MAX_B_ROWS) * clamp_size(rl_reg, MAX_ROW_LEN);
      if (load_pos >= total) load_pos = 0;
      b_matrix[load_pos] = v;
      load_pos++;
      if (load_pos >= total) load_pos = 0;
   endtask

   // Multiply one A element into every row sum; at row end queue the dot products
   task automatic accumulate_a_element(input logic signed [VALUE_W-1:0] v);
      int unsigned  nb;
      int unsigned  rl;
      int unsigned  col;
      int unsigned  j;
      longint       prod;
      dot_beat_type beat;
      nb  = clamp_size(nb_reg, MAX_B_ROWS);
      rl  = clamp_size(rl_reg, MAX_ROW_LEN);
      col = (col_pos < rl) ? col_pos : rl - 1;
      for (j = 0; j < nb; j++) begin
         prod        = longint'(v) * longint'(b_matrix[j * rl + col]);
         row_sums[j] = row_sums[j] + DOT_W'(prod);
      end
      if (col_pos + 1 >= rl) begin
         for (j = 0; j < nb; j++) begin
            beat.dot_value   = row_sums[j];
            beat.b_row_index = BROW_W'(j);
            beat.a_row_index = AROW_W'(a_row_count);
            beat.last        = (j + 1 == nb);
            dot_queue.push_back(beat);
         end
         row_sums = '{default: '0};
         col_pos  = 0;
         a_row_count++;
         if (a_row_count >= ((na_reg == 0) ? 1 : na_reg)) a_row_count = 0;
      end else begin
         col_pos++;
      end
   endtask

   // Compare one result beat with the oldest prediction, field by field
   task automatic check_dot_beat();
      dot_beat_type want;
      if (dot_queue.size() == 0) begin
         $error("result beat with no dot product pending: b_row_index %0d, a_row_index %0d",
                rsp_if.b_row_index, rsp_if.a_row_index);
         fails++;
         return;
      end
      want = dot_queue.pop_front();
      matched++;
      if (rsp_if.dot_value !== want.dot_value) begin
         $error("dot_value: expected %0d, got %0d", want.dot_value, rsp_if.dot_value);
         fails++;
      end
      if (rsp_if.b_row_index !== want.b_row_index) begin
         $error("b_row_index: expected %0d, got %0d", want.b_row_index, rsp_if.b_row_index);
         fails++;
      end
      if (rsp_if.a_row_index !== want.a_row_index) begin
         $error("a_row_index: expected %0d, got %0d", want.a_row_index, rsp_if.a_row_index);
         fails++;
      end
      if (rsp_if.last !== want.last) begin
         $error("last: expected %0b, got %0b", want.last, rsp_if.last);
         fails++;
      end
   endtask

   // Track every beat on the three channels at the clock edge
   always @(posedge clock) begin
      if (reset) begin
         nb_reg      = NUM_B_ROWS_RESET;
         rl_reg      = ROW_LENGTH_RESET;
         na_reg      = NUM_A_ROWS_RESET;
         row_sums    = '{default: '0};
         load_pos    = 0;
         col_pos     = 0;
         a_row_count = 0;
         dot_queue.delete();
      end else begin
         if (csr_if.valid && csr_if.ready) begin
            case (csr_index_type'(csr_if.index))
               CSR_NUM_B_ROWS: nb_reg = csr_if.data[NB_W-1:0];
               CSR_ROW_LENGTH: rl_reg = csr_if.data[RL_W-1:0];
               CSR_NUM_A_ROWS: na_reg = csr_if.data[NA_W-1:0];
               default: ;
            endcase
         end
         if (rsp_if.valid && rsp_if.ready) check_dot_beat();
         if (req_if.valid && req_if.ready) begin
            if (req_if.action == ACT_FEED_A) accumulate_a_element(req_if.value);
            else store_b_element(req_if.value);
         end
      end
      pending    <= dot_queue.size();
      fail_count <= fails;
      checked    <= matched;
   end

endmodule

[tb/matrix_multiply_transposed_test.sv]
// Top of the A times B-transpose test: clock, reset, B loads, A rows and
// register writes under random stalls, and the final verdict.
// Depends on mmt_pkg, mmt_if, the block and matrix_multiply_transposed_checker.
module matrix_multiply_transposed_test;
   import mmt_pkg::*;

   localparam int CYCLE_LIMIT   = 2_000_000;
   localparam int SETTLE_CYCLES = 3 * MAX_B_ROWS + 8;
   localparam int RANDOM_BEATS  = 45;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending;
   int   checked;
   int   tx_idle_pct = 17;
   int   rx_idle_pct = 56;
   int   beats_sent = 0;
   int   csr_writes = 0;
   int   cycle_count = 0;
   bit   pin_values = 1'b0;

   mmt_req_if req_if ();
   mmt_rsp_if rsp_if ();
   mmt_csr_if csr_if ();

   matrix_multiply_transposed dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   matrix_multiply_transposed_checker dot_check (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .rsp_if     (rsp_if),
      .csr_if     (csr_if),
      .fail_count (fail_count),
      .pending    (pending),
      .checked    (checked)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("matrix_multiply_transposed_test NOT OK");
         $finish;
      end
   end

   // Result side: drop ready at random
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_if.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   function automatic int clamp_size(input int raw, input int hi);
      if (raw < 1) return 1;
      return (raw > hi) ? hi : raw;
   endfunction

   // Element values lean toward the Q4.12 limits and small magnitudes
   function automatic logic signed [VALUE_W-1:0] element_value();
      if (pin_values) return 16'sh8000;
      case ($urandom_range(7))
         0:       return 16'sh8000;
         1:       return 16'sh7FFF;
         2:       return VALUE_W'(int'($urandom_range(8)) - 4);
         default: return VALUE_W'($urandom);
      endcase
   endfunction

   // Offer one beat, idling first at random; valid stays up after the handshake
   task automatic send_element(input logic act, input logic signed [VALUE_W-1:0] v);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid  <= 1'b1;
      req_if.action <= act;
      req_if.value  <= v;
      do @(posedge clock); while (!req_if.ready);
      beats_sent++;
   endtask

   // Hold the input side until every predicted dot product has come back
   task automatic wait_for_results();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // Junk above the register field must be ignored
   task automatic write_csr(input csr_index_type idx, input int raw, input int width);
      logic [CSR_DATA_W-1:0] data;
      data = CSR_DATA_W'(raw);
      if ($urandom_range(3) == 0) data = data | (CSR_DATA_W'($urandom) << width);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= data;
      do @(posedge clock); while (!csr_if.ready);
      csr_writes++;
   endtask

   // Stream A elements with a few B writes mixed in
   task automatic feed_a(input int count, input int noise_pct);
      repeat (count) begin
         if ($urandom_range(99) < noise_pct) send_element(ACT_LOAD_B, element_value());
         send_element(ACT_FEED_A, element_value());
         if ($urandom_range(29) == 0) wait_for_results();
      end
   endtask

   // Quiesce, set a new shape, refill B over the whole shape, then stream A;
   // a negative b_extra loads only the first elements of the shape
   task automatic run_shape(input int nb_raw, input int rl_raw, input int na_raw,
                            input int b_extra, input int a_count, input int noise_pct);
      int total;
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_csr(CSR_NUM_B_ROWS, nb_raw, NB_W);
      write_csr(CSR_ROW_LENGTH, rl_raw, RL_W);
      write_csr(CSR_NUM_A_ROWS, na_raw, NA_W);
      csr_if.valid <= 1'b0;
      total = clamp_size(nb_raw, MAX_B_ROWS) * clamp_size(rl_raw, MAX_ROW_LEN);
      repeat (total + b_extra) send_element(ACT_LOAD_B, element_value());
      feed_a(a_count, noise_pct);
   endtask

   initial begin
      int first_random;
      int mix;
      int nb;
      int rl;
      int na;
      int total;
      int b_extra;
      int a_count;

      reset         = 1'b1;
      req_if.valid  = 1'b0;
      req_if.action = ACT_LOAD_B;
      req_if.value  = '0;
      csr_if.valid  = 1'b0;
      csr_if.index  = CSR_NUM_B_ROWS;
      csr_if.data   = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Reset row count and A row wrap with one-element rows: 64 B rows per A element
      write_csr(CSR_ROW_LENGTH, 1, RL_W);
      csr_if.valid <= 1'b0;
      repeat (MAX_B_ROWS) send_element(ACT_LOAD_B, element_value());
      feed_a(2, 0);
      // Leave a row half done, then shorten it: the next A element closes it
      run_shape(2, 4, 3, 0, 6, 0);
      // Row count wraps at 3
      run_shape(2, 2, 3, 0, 3, 0);
      // Zero sizes act as one: each A element is a whole row
      run_shape(0, 0, 0, 0, 0, 0);
      send_element(ACT_FEED_A, 16'sh7FFF);
      send_element(ACT_FEED_A, 16'sh8000);
      send_element(ACT_FEED_A, -16'sd1);
      send_element(ACT_FEED_A, 16'sd0);
      // Oversized B row count saturates; rows past the fresh loads keep older values
      run_shape(100, 1, 2, -54, 1, 0);
      // Write position now lies past the smaller shape and wraps on the next load
      run_shape(2, 2, 2, 0, 5, 20);
      // Oversized row length saturates; load only the columns read, leave a row open
      run_shape(1, 300, 2, -251, 5, 0);

      // Random shapes, mostly small: sender idles 17 and receiver 56, then the
      // other way round, then neither
      first_random = beats_sent;
      for (mix = 0; mix < 3; mix++) begin
         tx_idle_pct = (mix == 0) ? 17 : (mix == 1) ? 56 : 0;
         rx_idle_pct = (mix == 0) ? 56 : (mix == 1) ? 17 : 0;
         while (beats_sent - first_random < (mix + 1) * RANDOM_BEATS / 3) begin
            nb = $urandom_range(1, 4);
            rl = $urandom_range(1, 4);
            case ($urandom_range(9))
               0: begin
                  nb = $urandom_range(1) ? 0 : $urandom_range(MAX_B_ROWS + 1, 127);
                  rl = $urandom_range(1, 2);
               end
               1: rl = 0;
               default: ;
            endcase
            case ($urandom_range(3))
               0:       na = 0;
               1:       na = 16'hFFFF;
               default: na = $urandom_range(1, 4);
            endcase
            total   = clamp_size(nb, MAX_B_ROWS) * clamp_size(rl, MAX_ROW_LEN);
            b_extra = ($urandom_range(3) == 0) ? $urandom_range(1, total) : 0;
            a_count = $urandom_range(1, 3) * clamp_size(rl, MAX_ROW_LEN)
                      + $urandom_range(0, clamp_size(rl, MAX_ROW_LEN) - 1);
            run_shape(nb, rl, na, b_extra, a_count, 10);
         end
      end

      // Close any open row, then a pinned row at the negative limit
      run_shape(1, 1, 1, 0, 1, 0);
      pin_values = 1'b1;
      run_shape(1, 4, 16'hFFFF, 0, 4, 0);
      pin_values = 1'b0;

      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Sent %0d beats and %0d register writes; %0d dot products compared.",
               beats_sent, csr_writes, checked);
      $display("Shapes up to 64 B rows and 256-element rows, saturated sizes, resizes, wraps.");
      if (fail_count == 0) begin
         $display("matrix_multiply_transposed_test OK");
      end else begin
         $display("matrix_multiply_transposed_test NOT OK");
      end
      $finish;
   end

endmodule

[sim.f]
src/mmt_pkg.sv
src/mmt_if.sv
src/mmt_ram.sv
src/matrix_multiply_transposed.sv
src/mmt_checker.sv
tb/matrix_multiply_transposed_checker.sv
tb/matrix_multiply_transposed_test.sv
